// File: design/assert_macros.svh
// Concurrent assertion helpers, sampled on i_clk and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/gqsb_pkg.sv
`timescale 1ns / 1ps
package gqsb_pkg;

    localparam int COORD_FRAC_BITS_DEF  = 8;
    localparam int UV_FRAC_BITS_DEF     = 16;
    localparam int ATLAS_COORD_BITS_DEF = 12;

    localparam logic [1:0] FN_FRAME = 2'd0;
    localparam logic [1:0] FN_RUN   = 2'd1;
    localparam logic [1:0] FN_GLYPH = 2'd2;

    localparam logic CFG_PAGE_W = 1'b0;
    localparam logic CFG_PAGE_H = 1'b1;

    localparam logic [12:0] PAGE_RESET = 13'd1024;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] run_scale;
        logic [31:0]        run_color;
        logic signed [15:0] bearing_x;
        logic signed [15:0] bearing_y;
        logic [11:0]        glyph_w;
        logic [11:0]        glyph_h;
        logic               hit;
        logic [7:0]         atlas_page;
        logic [47:0]        atlas_rect;
    } t_in;

    typedef struct packed {
        logic signed [31:0] quad_x0;
        logic signed [31:0] quad_y0;
        logic signed [31:0] quad_x1;
        logic signed [31:0] quad_y1;
        logic [16:0]        tex_u0;
        logic [16:0]        tex_v0;
        logic [16:0]        tex_u1;
        logic [16:0]        tex_v1;
        logic [7:0]         out_page;
        logic [31:0]        out_color;
        logic               new_batch;
        logic [15:0]        batch_index;
    } t_out;

    typedef struct packed {
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic [14:0]        scale;
        logic [31:0]        color;
        logic               new_batch;
        logic [15:0]        batch_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] bearing_x;
        logic signed [15:0] bearing_y;
        logic [11:0]        glyph_w;
        logic [11:0]        glyph_h;
        logic [7:0]         page;
        logic [47:0]        rect;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CORN,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } t_be_state;

endpackage

// File: design/gqsb_front.sv
`timescale 1ns / 1ps
module gqsb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  gqsb_pkg::t_in    i_data,
    output logic             o_stall,
    input  gqsb_pkg::t_fifo_st i_fst,
    output logic             o_push,
    output gqsb_pkg::t_job   o_job
);
    import gqsb_pkg::*;

    logic signed [23:0] r_ox, r_oy;
    logic [14:0]        r_scale;
    logic [31:0]        r_color;
    logic [7:0]         r_last;
    logic               r_have;
    logic [15:0]        r_cnt;
    logic               w_acc, w_nb;
    logic [15:0]        w_idx;

    assign o_stall = i_fst.full;
    assign w_acc   = i_valid && !i_fst.full;
    assign w_nb    = !r_have || (r_last != i_data.atlas_page);
    assign w_idx   = (r_have && w_nb) ? r_cnt + 16'd1 : r_cnt;
    assign o_push  = w_acc && (i_data.func == FN_GLYPH) && i_data.hit;

    always_comb begin
        o_job.origin_x    = r_ox;
        o_job.origin_y    = r_oy;
        o_job.scale       = r_scale;
        o_job.color       = r_color;
        o_job.new_batch   = w_nb;
        o_job.batch_index = w_idx;
        o_job.pos_x       = i_data.pos_x;
        o_job.pos_y       = i_data.pos_y;
        o_job.bearing_x   = i_data.bearing_x;
        o_job.bearing_y   = i_data.bearing_y;
        o_job.glyph_w     = i_data.glyph_w;
        o_job.glyph_h     = i_data.glyph_h;
        o_job.page        = i_data.atlas_page;
        o_job.rect        = i_data.atlas_rect;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox    <= '0;
            r_oy    <= '0;
            r_scale <= '0;
            r_color <= '0;
            r_last  <= '0;
            r_have  <= 1'b0;
            r_cnt   <= '0;
        end else if (w_acc) begin
            case (i_data.func)
                FN_FRAME: begin
                    r_have <= 1'b0;
                    r_cnt  <= '0;
                end
                FN_RUN: begin
                    r_ox    <= i_data.pos_x;
                    r_oy    <= i_data.pos_y;
                    r_scale <= i_data.run_scale[15] ? 15'd0 : i_data.run_scale[14:0];
                    r_color <= i_data.run_color;
                end
                FN_GLYPH: begin
                    if (i_data.hit) begin
                        r_have <= 1'b1;
                        r_last <= i_data.atlas_page;
                        r_cnt  <= w_idx;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: design/gqsb_fifo.sv
`timescale 1ns / 1ps
module gqsb_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gqsb_pkg::t_job     i_job,
    input  logic               i_pop,
    output gqsb_pkg::t_job     o_job,
    output gqsb_pkg::t_fifo_st o_st
);
    import gqsb_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_st.full  = (r_cnt == 2'd2);
    assign o_st.empty = (r_cnt == 2'd0);
    assign o_job      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// File: design/gqsb_back.sv
`timescale 1ns / 1ps
module gqsb_back #(
    parameter int COORD_FRAC_BITS  = gqsb_pkg::COORD_FRAC_BITS_DEF,
    parameter int UV_FRAC_BITS     = gqsb_pkg::UV_FRAC_BITS_DEF,
    parameter int ATLAS_COORD_BITS = gqsb_pkg::ATLAS_COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gqsb_pkg::t_job     i_job,
    input  gqsb_pkg::t_fifo_st i_fst,
    output logic               o_pop,
    input  logic [12:0]        i_page_w,
    input  logic [12:0]        i_page_h,
    output logic               o_valid,
    output gqsb_pkg::t_out     o_data,
    input  logic               i_stall
);
    import gqsb_pkg::*;

    localparam int CF   = COORD_FRAC_BITS;
    localparam int UV   = UV_FRAC_BITS;
    localparam int AB   = ATLAS_COORD_BITS;
    localparam int DXW  = (CF + 18 > 26) ? CF + 18 : 26;
    localparam int PW   = DXW + 17;
    localparam int SW   = PW - 5;
    localparam int TW   = AB + 2;
    localparam int NUMW = AB + 3 + UV;
    localparam int BCW  = $clog2(NUMW);
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< 31) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< 31);

    t_be_state r_st, n_st;

    logic signed [PW-1:0]  r_prod [4];
    logic signed [SW-1:0]  r_q [4];
    logic [16:0]           r_tex [4];
    logic                  r_nat;
    logic [1:0]            r_mcnt, r_dcnt;
    logic [NUMW-1:0]       r_num, r_qt;
    logic [14:0]           r_rem, r_den;
    logic [BCW-1:0]        r_bcnt;
    logic                  r_ov;
    t_out                  r_out;

    logic [63:0]           w_rect;
    logic [AB-1:0]         w_cx, w_cy, w_cw, w_ch;
    logic signed [DXW-1:0] w_dx, w_dy, w_gw, w_gh, w_ma;
    logic signed [PW-1:0]  w_prod;
    logic                  w_nat, w_load, w_ddone;
    logic signed [SW-1:0]  w_t [4];
    logic signed [SW-1:0]  w_x0, w_y0, w_x1, w_y1;
    logic signed [SW-1:0]  w_c [4];
    logic [TW-1:0]         w_tt;
    logic                  w_iu, w_iv;
    logic [12:0]           w_sz;
    logic [15:0]           w_remn;
    logic                  w_qb;
    logic [NUMW-1:0]       w_qn;
    logic [16:0]           w_qs;

    function automatic logic signed [SW-1:0] snap(input logic signed [SW-1:0] v);
        logic [SW-1:0] mag;
        mag = v[SW-1] ? SW'(-v) : SW'(v);
        mag = ((mag + (SW'(1) << (CF - 1))) >> CF) << CF;
        return v[SW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [SW-1:0] sat(input logic signed [SW-1:0] v);
        if (v > MAXV) return MAXV;
        if (v < MINV) return MINV;
        return v;
    endfunction

    assign w_rect = {16'd0, i_job.rect};
    assign w_cx   = w_rect[3*AB +: AB];
    assign w_cy   = w_rect[2*AB +: AB];
    assign w_cw   = w_rect[AB +: AB];
    assign w_ch   = w_rect[0 +: AB];

    assign w_dx = DXW'(i_job.pos_x) + (DXW'(i_job.bearing_x) <<< CF) - DXW'(i_job.origin_x);
    assign w_dy = DXW'(i_job.pos_y) - (DXW'(i_job.bearing_y) <<< CF) - DXW'(i_job.origin_y);
    assign w_gw = DXW'($signed({1'b0, i_job.glyph_w})) <<< CF;
    assign w_gh = DXW'($signed({1'b0, i_job.glyph_h})) <<< CF;

    always_comb begin
        case (r_mcnt)
            2'd0:    w_ma = w_dx;
            2'd1:    w_ma = w_dy;
            2'd2:    w_ma = w_gw;
            default: w_ma = w_gh;
        endcase
    end
    assign w_prod = PW'(w_ma) * PW'($signed({2'b00, i_job.scale}));

    assign w_nat = (i_job.scale == 15'd256) && (16'(i_job.glyph_w) == 16'(w_cw))
                   && (16'(i_job.glyph_h) == 16'(w_ch));

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_t[k] = SW'((r_prod[k] + PW'(128)) >>> 8);
        end
        w_x0 = SW'(i_job.origin_x) + w_t[0];
        w_y0 = SW'(i_job.origin_y) + w_t[1];
        w_x1 = w_x0 + w_t[2];
        w_y1 = w_y0 + w_t[3];
        if (w_nat) begin
            w_x0 = snap(w_x0);
            w_y0 = snap(w_y0);
            w_x1 = w_x0 + (SW'($signed({1'b0, w_cw})) <<< CF);
            w_y1 = w_y0 + (SW'($signed({1'b0, w_ch})) <<< CF);
        end
        w_c[0] = sat(w_x0);
        w_c[1] = sat(w_y0);
        w_c[2] = sat(w_x1);
        w_c[3] = sat(w_y1);
    end

    assign w_iu = r_nat && (w_cw > AB'(1));
    assign w_iv = r_nat && (w_ch > AB'(1));

    always_comb begin
        case (r_dcnt)
            2'd0:    w_tt = TW'({w_cx, 1'b0}) + TW'(w_iu);
            2'd1:    w_tt = TW'({w_cy, 1'b0}) + TW'(w_iv);
            2'd2:    w_tt = ((TW'(w_cx) + TW'(w_cw)) << 1) - TW'(w_iu);
            default: w_tt = ((TW'(w_cy) + TW'(w_ch)) << 1) - TW'(w_iv);
        endcase
        w_sz = r_dcnt[0] ? i_page_h : i_page_w;
        if (w_sz == 13'd0) w_sz = 13'd1;
    end

    assign w_remn  = {r_rem, r_num[NUMW-1]};
    assign w_qb    = (w_remn >= {1'b0, r_den});
    assign w_qn    = {r_qt[NUMW-2:0], w_qb};
    assign w_qs    = (w_qn > (NUMW'(1) << UV)) ? 17'(NUMW'(1) << UV) : 17'(w_qn);
    assign w_ddone = (r_bcnt == BCW'(NUMW - 1));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (!i_fst.empty) n_st = ST_MUL;
            ST_MUL:   if (r_mcnt == 2'd3) n_st = ST_CORN;
            ST_CORN:  n_st = ST_DLOAD;
            ST_DLOAD: n_st = ST_DIV;
            ST_DIV:   if (w_ddone) n_st = (r_dcnt == 2'd3) ? ST_OUT : ST_DLOAD;
            ST_OUT:   if (!r_ov || !i_stall) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        w_load = 1'b0;
        unique case (r_st)
            ST_OUT:  w_load = !r_ov || !i_stall;
            default: w_load = 1'b0;
        endcase
    end
    assign o_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_ov   <= 1'b0;
            r_mcnt <= '0;
            r_dcnt <= '0;
            r_bcnt <= '0;
        end else begin
            r_st <= n_st;
            if (w_load) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE:  r_mcnt <= '0;
                ST_MUL:   r_mcnt <= r_mcnt + 2'd1;
                ST_CORN:  r_dcnt <= '0;
                ST_DLOAD: r_bcnt <= '0;
                ST_DIV: begin
                    r_bcnt <= r_bcnt + BCW'(1);
                    if (w_ddone) r_dcnt <= r_dcnt + 2'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_MUL: r_prod[r_mcnt] <= w_prod;
            ST_CORN: begin
                for (int k = 0; k < 4; k++) r_q[k] <= w_c[k];
                r_nat <= w_nat;
            end
            ST_DLOAD: begin
                r_num <= (NUMW'(w_tt) << UV) + NUMW'(w_sz);
                r_den <= {1'b0, w_sz, 1'b0};
                r_rem <= '0;
                r_qt  <= '0;
            end
            ST_DIV: begin
                r_num <= r_num << 1;
                r_rem <= w_qb ? 15'(w_remn - {1'b0, r_den}) : w_remn[14:0];
                r_qt  <= w_qn;
                if (w_ddone) r_tex[r_dcnt] <= w_qs;
            end
            default: ;
        endcase
        if (w_load) begin
            r_out.quad_x0     <= r_q[0][31:0];
            r_out.quad_y0     <= r_q[1][31:0];
            r_out.quad_x1     <= r_q[2][31:0];
            r_out.quad_y1     <= r_q[3][31:0];
            if (w_cw != '0 && w_ch != '0) begin
                r_out.tex_u0 <= r_tex[0];
                r_out.tex_v0 <= r_tex[1];
                r_out.tex_u1 <= r_tex[2];
                r_out.tex_v1 <= r_tex[3];
            end else begin
                r_out.tex_u0 <= '0;
                r_out.tex_v0 <= '0;
                r_out.tex_u1 <= '0;
                r_out.tex_v1 <= '0;
            end
            r_out.out_page    <= i_job.page;
            r_out.out_color   <= i_job.color;
            r_out.new_batch   <= i_job.new_batch;
            r_out.batch_index <= i_job.batch_index;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule

// File: design/glyph_quad_setup_batcher.sv
`timescale 1ns / 1ps
// Glyph quad setup with page batching. Frame and run items are absorbed by the
// front end; a hit glyph is queued (two deep) and then passes through the back
// end: four passes through one shared scale multiplier, a corner step, and four
// bit-serial texture divisions of NUM-bit numerators by twice the page size,
// NUM = ATLAS_COORD_BITS + UV_FRAC_BITS + 3. The result sits in an output
// register so the next glyph proceeds while it waits. The user must write the
// page size registers only while the block is idle, which it does not enforce.
module glyph_quad_setup_batcher #(
    parameter int COORD_FRAC_BITS  = gqsb_pkg::COORD_FRAC_BITS_DEF,
    parameter int UV_FRAC_BITS     = gqsb_pkg::UV_FRAC_BITS_DEF,
    parameter int ATLAS_COORD_BITS = gqsb_pkg::ATLAS_COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gqsb_pkg::t_in  i_data,
    output logic           o_stall,
    output logic           o_valid,
    output gqsb_pkg::t_out o_data,
    input  logic           i_stall,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [12:0]    i_cfg_data
);
    import gqsb_pkg::*;
    `include "assert_macros.svh"

    logic [12:0] r_page_w, r_page_h;
    logic        w_push, w_pop;
    t_job        w_jin, w_jout;
    t_fifo_st    w_fst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_w <= PAGE_RESET;
            r_page_h <= PAGE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAGE_W: r_page_w <= i_cfg_data;
                CFG_PAGE_H: r_page_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gqsb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_fst   (w_fst),
        .o_push  (w_push),
        .o_job   (w_jin)
    );

    gqsb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_jin),
        .i_pop   (w_pop),
        .o_job   (w_jout),
        .o_st    (w_fst)
    );

    gqsb_back #(
        .COORD_FRAC_BITS  (COORD_FRAC_BITS),
        .UV_FRAC_BITS     (UV_FRAC_BITS),
        .ATLAS_COORD_BITS (ATLAS_COORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_jout),
        .i_fst    (w_fst),
        .o_pop    (w_pop),
        .i_page_w (r_page_w),
        .i_page_h (r_page_h),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .i_stall  (i_stall)
    );

    `ASSERT_IMPL(a_pop_nonempty, w_pop, !w_fst.empty)
    `ASSERT_IMPL(a_push_room, w_push, !w_fst.full)
    `ASSERT_NEXT(a_push_lands, w_push && !w_pop, !w_fst.empty)
    `ASSERT_NEXT(a_pop_loads, w_pop, o_valid)
endmodule

// File: verif/tb_glyph_quad_setup_batcher.sv
`timescale 1ns / 1ps
module tb_glyph_quad_setup_batcher;
    import gqsb_pkg::*;

    localparam logic [1:0] FN_SPARE = 2'd3;

    class quad_scoreboard;
        longint pg_w = 1024, pg_h = 1024;
        longint org_x, org_y, scl;
        logic [31:0] color = '0;
        logic [7:0] last_pg = '0;
        bit have_batch;
        logic [15:0] batch_cnt = '0;
        t_out quads[$];
        int errors;

        function longint scale_term(longint v, longint s);
            return (v * s + 128) >>> 8;
        endfunction

        function longint snap(longint v);
            longint mag;
            mag = v < 0 ? -v : v;
            mag = ((mag + 128) >>> 8) <<< 8;
            return v < 0 ? -mag : mag;
        endfunction

        function logic [31:0] sat32(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function logic [16:0] tex(longint tt, longint size);
            longint den, q;
            den = 2 * (size == 0 ? 1 : size);
            if (tt <= 0) return 0;
            q = ((tt <<< 16) + den / 2) / den;
            if (q > 65536) q = 65536;
            return q[16:0];
        endfunction

        function void note(t_in d);
            longint px, py, bx, by, gw, gh, cx, cy, cw, ch, x0, y0, x1, y1, ix, iy;
            bit native;
            t_out r;
            px = longint'($signed(d.pos_x));
            py = longint'($signed(d.pos_y));
            if (d.func == FN_FRAME) begin
                have_batch = 0;
                batch_cnt = 0;
                return;
            end
            if (d.func == FN_RUN) begin
                org_x = px;
                org_y = py;
                scl = $signed(d.run_scale) < 0 ? 0 : longint'($signed(d.run_scale));
                color = d.run_color;
                return;
            end
            if (d.func != FN_GLYPH || !d.hit) return;
            bx = longint'($signed(d.bearing_x));
            by = longint'($signed(d.bearing_y));
            gw = d.glyph_w;
            gh = d.glyph_h;
            cx = d.atlas_rect[47:36];
            cy = d.atlas_rect[35:24];
            cw = d.atlas_rect[23:12];
            ch = d.atlas_rect[11:0];
            x0 = org_x + scale_term(px + bx * 256 - org_x, scl);
            y0 = org_y + scale_term(py - by * 256 - org_y, scl);
            x1 = x0 + scale_term(gw * 256, scl);
            y1 = y0 + scale_term(gh * 256, scl);
            native = scl == 256 && gw == cw && gh == ch;
            if (native) begin
                x0 = snap(x0);
                y0 = snap(y0);
                x1 = x0 + cw * 256;
                y1 = y0 + ch * 256;
            end
            r.quad_x0 = sat32(x0);
            r.quad_y0 = sat32(y0);
            r.quad_x1 = sat32(x1);
            r.quad_y1 = sat32(y1);
            if (cw > 0 && ch > 0) begin
                ix = (native && cw > 1) ? 1 : 0;
                iy = (native && ch > 1) ? 1 : 0;
                r.tex_u0 = tex(2 * cx + ix, pg_w);
                r.tex_v0 = tex(2 * cy + iy, pg_h);
                r.tex_u1 = tex(2 * (cx + cw) - ix, pg_w);
                r.tex_v1 = tex(2 * (cy + ch) - iy, pg_h);
            end else begin
                r.tex_u0 = 0;
                r.tex_v0 = 0;
                r.tex_u1 = 0;
                r.tex_v1 = 0;
            end
            r.out_page = d.atlas_page;
            r.out_color = color;
            if (!have_batch || last_pg != d.atlas_page) begin
                if (have_batch) batch_cnt = batch_cnt + 1;
                have_batch = 1;
                last_pg = d.atlas_page;
                r.new_batch = 1;
            end else begin
                r.new_batch = 0;
            end
            r.batch_index = batch_cnt;
            quads.push_back(r);
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a) begin
                $error("%s expected %0h actual %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check(t_out a);
            t_out e;
            if (quads.size() == 0) begin
                $error("unexpected transfer %h", a);
                errors++;
                return;
            end
            e = quads.pop_front();
            cmp("quad_x0", e.quad_x0, a.quad_x0);
            cmp("quad_y0", e.quad_y0, a.quad_y0);
            cmp("quad_x1", e.quad_x1, a.quad_x1);
            cmp("quad_y1", e.quad_y1, a.quad_y1);
            cmp("tex_u0", e.tex_u0, a.tex_u0);
            cmp("tex_v0", e.tex_v0, a.tex_v0);
            cmp("tex_u1", e.tex_u1, a.tex_u1);
            cmp("tex_v1", e.tex_v1, a.tex_v1);
            cmp("out_page", e.out_page, a.out_page);
            cmp("out_color", e.out_color, a.out_color);
            cmp("new_batch", e.new_batch, a.new_batch);
            cmp("batch_index", e.batch_index, a.batch_index);
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0, o_stall, o_valid;
    logic i_cfg_we = 0, i_cfg_idx = CFG_PAGE_W;
    logic [12:0] i_cfg_data = 0;
    t_in i_data = '0;
    t_out o_data;
    int send_idle, recv_idle;
    quad_scoreboard sb = new();

    glyph_quad_setup_batcher dut (.*);

    initial forever #4 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall) sb.check(o_data);

    task automatic send(t_in d);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1;
        i_data = d;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note(d);
    endtask

    task automatic cfg_write(logic idx, logic [12:0] val);
        @(negedge i_clk);
        i_valid = 0;
        while (sb.quads.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        if (idx == CFG_PAGE_W) sb.pg_w = val;
        else sb.pg_h = val;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    function automatic t_in mk(logic [1:0] f, int x, int y, int s, int bx, int by,
                               int w, int h, logic [7:0] pg, logic [47:0] rect);
        t_in d;
        d = '0;
        d.func = f;
        d.pos_x = x;
        d.pos_y = y;
        d.run_scale = s;
        d.run_color = $urandom;
        d.bearing_x = bx;
        d.bearing_y = by;
        d.glyph_w = w;
        d.glyph_h = h;
        d.hit = 1;
        d.atlas_page = pg;
        d.atlas_rect = rect;
        return d;
    endfunction

    function automatic t_in rnd_item();
        t_in d;
        int k;
        logic [11:0] cw, ch;
        d = $bits(t_in)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom});
        k = $urandom_range(99);
        if (k < 6) d.func = FN_FRAME;
        else if (k < 20) d.func = FN_RUN;
        else if (k < 96) d.func = FN_GLYPH;
        else d.func = FN_SPARE;
        if ($urandom_range(9) < 7) begin
            d.pos_x = $signed($urandom_range(131071)) - 65536;
            d.pos_y = $signed($urandom_range(131071)) - 65536;
        end
        case ($urandom_range(4))
            0, 1: d.run_scale = 256;
            2: d.run_scale = $urandom_range(1024);
            default: ;
        endcase
        d.hit = $urandom_range(9) != 0;
        if ($urandom_range(4) != 0) begin
            d.bearing_x = $signed($urandom_range(64)) - 32;
            d.bearing_y = $signed($urandom_range(64)) - 32;
        end
        d.atlas_page = $urandom_range(3);
        if ($urandom_range(9) != 0) begin
            cw = $urandom_range(40);
            ch = $urandom_range(40);
            d.atlas_rect = {12'($urandom_range(1000)), 12'($urandom_range(1000)), cw, ch};
            if ($urandom_range(1)) begin
                d.glyph_w = cw;
                d.glyph_h = ch;
            end else begin
                d.glyph_w = $urandom_range(40);
                d.glyph_h = $urandom_range(40);
            end
        end
        return d;
    endfunction

    initial begin
        t_in d;
        send_idle = 0;
        recv_idle = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send(mk(FN_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FN_GLYPH, 100, 200, 0, 1, 1, 5, 5, 0, {12'd1, 12'd2, 12'd5, 12'd5}));
        send(mk(FN_RUN, 0, 0, 256, 0, 0, 0, 0, 0, 0));
        send(mk(FN_GLYPH, 383, -383, 0, 2, -3, 8, 9, 1, {12'd10, 12'd20, 12'd8, 12'd9}));
        send(mk(FN_GLYPH, 128, -128, 0, 0, 0, 1, 1, 1, {12'd0, 12'd0, 12'd1, 12'd1}));
        d = mk(FN_GLYPH, 5, 5, 0, 0, 0, 3, 3, 2, {12'd1, 12'd1, 12'd3, 12'd3});
        d.hit = 0;
        send(d);
        send(mk(FN_SPARE, 1, 1, 256, 1, 1, 1, 1, 7, 48'hFFF));
        send(mk(FN_RUN, -8388608, 8388607, -32768, 0, 0, 0, 0, 0, 0));
        send(mk(FN_GLYPH, 8388607, -8388608, 0, -32768, 32767, 4095, 4095, 255, '1));
        send(mk(FN_RUN, -8388608, -8388608, 32767, 0, 0, 0, 0, 0, 0));
        send(mk(FN_GLYPH, 8388607, 8388607, 0, 32767, -32768, 4095, 4095, 255, '1));
        send(mk(FN_GLYPH, 0, 0, 0, 0, 0, 0, 7, 0, {12'd5, 12'd5, 12'd0, 12'd7}));
        send(mk(FN_RUN, 1000, -1000, 256, 0, 0, 0, 0, 0, 0));
        send(mk(FN_GLYPH, 2000, 3000, 0, 4, 4, 4095, 4095, 3, {12'd0, 12'd0, 12'hFFF, 12'hFFF}));
        send(mk(FN_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FN_GLYPH, -7, 7, 0, 0, 0, 2, 2, 3, {12'd4, 12'd4, 12'd2, 12'd2}));

        cfg_write(CFG_PAGE_W, 13'd1);
        cfg_write(CFG_PAGE_H, 13'd4096);
        send_idle = 37;
        recv_idle = 85;
        repeat (310) send(rnd_item());

        cfg_write(CFG_PAGE_W, 13'd0);
        cfg_write(CFG_PAGE_H, 13'h1FFF);
        send_idle = 85;
        recv_idle = 37;
        repeat (310) send(rnd_item());

        cfg_write(CFG_PAGE_W, 13'd4096);
        cfg_write(CFG_PAGE_H, 13'd1);
        send_idle = 0;
        recv_idle = 0;
        repeat (150) send(rnd_item());
        cfg_write(CFG_PAGE_W, 13'd1024);
        cfg_write(CFG_PAGE_H, 13'd777);
        repeat (160) send(rnd_item());

        @(negedge i_clk);
        i_valid = 0;
        while (sb.quads.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
